// ===== design/vtdi_pkg.sv =====
// Shared types, constants and helpers for the vertex triple de-duplicating indexer.
// No dependencies; every other design file refers to this package by scoped names.
package vtdi_pkg;

  // Sizing of the vertex table
  localparam int unsigned MAX_VERTICES = 4096;
  localparam int unsigned INDEX_BITS   = 16;

  // Capacity is the smaller of the table depth and the index space
  localparam longint unsigned IDX_LIMIT = 64'd1 << INDEX_BITS;
  localparam int unsigned CAPACITY =
    (IDX_LIMIT < 64'(MAX_VERTICES)) ? int'(IDX_LIMIT) : MAX_VERTICES;

  localparam int unsigned ADDR_W  = $clog2(CAPACITY);
  localparam int unsigned COUNT_W = $clog2(CAPACITY + 1);

  // Field widths of one corner and one result
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned VIDX_W  = 12;

  typedef struct packed {
    logic [FIELD_W-1:0] position_index;
    logic [FIELD_W-1:0] texcoord_index;
    logic [FIELD_W-1:0] normal_index;
  } triple_t;

  // Write request into the vertex table
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    triple_t           data;
  } tbl_wr_t;

  // Reduce a table slot number to the output index width (modulo 2^VIDX_W)
  function automatic logic [VIDX_W-1:0] to_vidx(input logic [ADDR_W-1:0] slot);
    logic [31:0] wide;
    wide = 32'(slot);
    return wide[VIDX_W-1:0];
  endfunction

endpackage

// ===== design/vtdi_corner_if.sv =====
// Corner input channel: valid/ready handshake with one index triple and mesh mark.
// Depends on vtdi_pkg for the field width.
interface vtdi_corner_if;
  logic                          valid;
  logic                          ready;
  logic [vtdi_pkg::FIELD_W-1:0]  position_index;
  logic [vtdi_pkg::FIELD_W-1:0]  texcoord_index;
  logic [vtdi_pkg::FIELD_W-1:0]  normal_index;
  logic                          last_of_mesh;

  modport source (
    output valid, position_index, texcoord_index, normal_index, last_of_mesh,
    input  ready
  );
  modport sink (
    input  valid, position_index, texcoord_index, normal_index, last_of_mesh,
    output ready
  );
endinterface

// ===== design/vtdi_result_if.sv =====
// Result output channel: valid/ready handshake with vertex index and status flags.
// Depends on vtdi_pkg for the index width.
interface vtdi_result_if;
  logic                         valid;
  logic                         ready;
  logic [vtdi_pkg::VIDX_W-1:0]  vertex_index;
  logic                         is_new;
  logic                         overflow;

  modport source (
    output valid, vertex_index, is_new, overflow,
    input  ready
  );
  modport sink (
    input  valid, vertex_index, is_new, overflow,
    output ready
  );
endinterface

// ===== design/vertex_triple_dedup_indexer.sv =====
// Vertex triple de-duplicating indexer: one corner at a time, linear search of the table
// in compress mode. A taken corner steps through StRead and StCmp for each slot searched,
// then StAlloc on a miss or with no search, and StFinish, which loads the output register.
// No new corner is taken until that result loads; a single comparator walks the table,
// one slot at a time through the registered read port.
// Reset clears the entry count and sets compress mode; table contents need no clearing pass.
module vertex_triple_dedup_indexer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  vtdi_corner_if.sink   corner_i,
  vtdi_result_if.source result_o
);

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StCmp,
    StAlloc,
    StFinish
  } state_e;

  state_e                          state_q;
  logic                            compress_q;
  logic [vtdi_pkg::COUNT_W-1:0]    count_q;
  logic [vtdi_pkg::ADDR_W-1:0]     scan_q;
  vtdi_pkg::triple_t               key_q;
  logic                            last_q;
  logic [vtdi_pkg::ADDR_W-1:0]     idx_q;
  logic                            new_q;
  logic                            ovf_q;
  logic                            res_valid_q;
  logic [vtdi_pkg::VIDX_W-1:0]     res_vidx_q;
  logic                            res_new_q;
  logic                            res_ovf_q;

  vtdi_pkg::tbl_wr_t               tbl_wr;
  vtdi_pkg::triple_t               rd_data;
  logic                            full;
  logic                            match;
  logic                            scan_last;
  logic                            out_free;
  logic                            res_load;

  vtdi_table u_table (
    .clk_i     (clk_i),
    .wr_i      (tbl_wr),
    .rd_addr_i (scan_q),
    .rd_data_o (rd_data)
  );

  // Shared compare and bookkeeping
  assign full      = (count_q >= vtdi_pkg::COUNT_W'(vtdi_pkg::CAPACITY));
  assign match     = (rd_data == key_q);
  assign scan_last = ((vtdi_pkg::COUNT_W'(scan_q) + vtdi_pkg::COUNT_W'(1)) == count_q);
  assign out_free  = !res_valid_q || result_o.ready;
  assign res_load  = (state_q == StFinish) && out_free;

  // Append the triple at the next free slot
  always_comb begin
    tbl_wr.en   = (state_q == StAlloc) && !full;
    tbl_wr.addr = count_q[vtdi_pkg::ADDR_W-1:0];
    tbl_wr.data = key_q;
  end

  assign corner_i.ready        = (state_q == StIdle);
  assign result_o.valid        = res_valid_q;
  assign result_o.vertex_index = res_vidx_q;
  assign result_o.is_new       = res_new_q;
  assign result_o.overflow     = res_ovf_q;

  // Sequencer: take a corner, walk the table in compress mode, allocate on a miss, hand over the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      compress_q  <= 1'b1;
      count_q     <= '0;
      scan_q      <= '0;
      key_q       <= '0;
      last_q      <= 1'b0;
      idx_q       <= '0;
      new_q       <= 1'b0;
      ovf_q       <= 1'b0;
      res_valid_q <= 1'b0;
      res_vidx_q  <= '0;
      res_new_q   <= 1'b0;
      res_ovf_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        compress_q <= cfg_wdata_i;
      end
      // Drop the result once transferred, unless the next one loads in the same cycle
      if (res_valid_q && result_o.ready && !res_load) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (corner_i.valid) begin
            key_q.position_index <= corner_i.position_index;
            key_q.texcoord_index <= corner_i.texcoord_index;
            key_q.normal_index   <= corner_i.normal_index;
            last_q               <= corner_i.last_of_mesh;
            scan_q               <= '0;
            if (compress_q && (count_q != '0)) begin
              state_q <= StRead;
            end else begin
              state_q <= StAlloc;
            end
          end
        end
        StRead: begin
          state_q <= StCmp;
        end
        StCmp: begin
          if (match) begin
            idx_q   <= scan_q;
            new_q   <= 1'b0;
            ovf_q   <= 1'b0;
            state_q <= StFinish;
          end else if (scan_last) begin
            state_q <= StAlloc;
          end else begin
            scan_q  <= scan_q + vtdi_pkg::ADDR_W'(1);
            state_q <= StRead;
          end
        end
        StAlloc: begin
          if (full) begin
            idx_q <= '0;
            new_q <= 1'b0;
            ovf_q <= 1'b1;
          end else begin
            idx_q   <= count_q[vtdi_pkg::ADDR_W-1:0];
            new_q   <= 1'b1;
            ovf_q   <= 1'b0;
            count_q <= count_q + vtdi_pkg::COUNT_W'(1);
          end
          state_q <= StFinish;
        end
        StFinish: begin
          // Hold until the output register is free
          if (out_free) begin
            res_valid_q <= 1'b1;
            res_vidx_q  <= vtdi_pkg::to_vidx(idx_q);
            res_new_q   <= new_q;
            res_ovf_q   <= ovf_q;
            if (last_q) begin
              count_q <= '0;
            end
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // Entry count never runs past the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= vtdi_pkg::COUNT_W'(vtdi_pkg::CAPACITY))
    else $error("entry count exceeds capacity");

  // An overflow result carries index 0 and is never new
  a_ovf_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.overflow |-> (result_o.vertex_index == '0) && !result_o.is_new)
    else $error("overflow result with non-zero index or new flag");

  // A table append advances the entry count by exactly one
  a_append_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_wr.en |=> count_q == $past(count_q) + vtdi_pkg::COUNT_W'(1))
    else $error("table append without count advance");

  // A corner transfer makes the block busy on the next cycle
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    corner_i.valid && corner_i.ready |=> !corner_i.ready)
    else $error("second corner taken while busy");

endmodule

// ===== design/vtdi_table.sv =====
// Vertex triple table: one write port and one read port with registered read data.
// Depends on vtdi_pkg for the triple type, write request and depth.
module vtdi_table (
  input  logic                         clk_i,
  input  vtdi_pkg::tbl_wr_t            wr_i,
  input  logic [vtdi_pkg::ADDR_W-1:0]  rd_addr_i,
  output vtdi_pkg::triple_t            rd_data_o
);

  vtdi_pkg::triple_t mem_q [vtdi_pkg::CAPACITY];
  vtdi_pkg::triple_t rd_data_q;

  // Store on write request, read every cycle into the output register
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule
